### hw/rtl/cbq_pkg.sv
// Package for the client byte quota table: item types, request kinds, engine states,
// register indexes and reset values.
// It depends on nothing; the top level, the front end and the engine use it.
package cbq_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned BytesW = 32;
  localparam int unsigned TimerW = 4;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgW   = 32;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_RELOAD    = 1'b1;

  localparam logic [BytesW-1:0] THRESHOLD_RST = 32'd1048576;
  localparam logic [TimerW-1:0] RELOAD_RST    = 4'd10;

  // Mode codes on the input stream
  localparam logic [ModeW-1:0] MODE_ADD     = 2'd0;
  localparam logic [ModeW-1:0] MODE_CHECK   = 2'd1;
  localparam logic [ModeW-1:0] MODE_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_CHECK,
    KIND_RELEASE,
    KIND_NONE
  } cbq_kind_e;

  typedef struct packed {
    cbq_kind_e         kind;
    logic [AddrW-1:0]  addr;
    logic [BytesW-1:0] bytes;
  } cbq_item_t;

  typedef struct packed {
    logic over_limit;
    logic table_full;
  } cbq_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE
  } cbq_state_e;

endpackage

### hw/rtl/client_byte_quota_table.sv
// Top level of the client byte quota table: configuration registers, front end and
// lookup engine. Depends on cbq_pkg, cbq_front and cbq_engine.
//
// Usage
//   Requests arrive on the s_axis channel, one per transfer: a mode (add bytes, check
//   client, release bytes), a client IPv4 address and a byte count. Every request gives
//   exactly one result transfer on m_axis with over_limit and table_full flags.
//   Two registers, the byte threshold and the penalty reload, are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no request is in flight.
// Processing
//   Each request sweeps the client table one slot a cycle through the table memory
//   read port, stopping at the first matching slot, then passes the arithmetic state
//   (ST_CALC) and the write state (ST_WRITE). The engine works on one request at a
//   time; the input queue holds two requests, so the sender may run ahead while one
//   is being processed.
// Reset
//   rst_ni clears every slot's valid bit at once and loads the register defaults
//   (threshold 1048576 bytes, reload 10); no clearing pass is needed.
// Back-pressure
//   A result waits in the output register until m_axis_tready_i; the engine starts
//   no new request until that register is free or draining, and the input queue
//   drops s_axis_tready_o when both of its places are full.
module client_byte_quota_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // mode[1:0], client_addr[33:2], byte_count[65:34]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // over_limit[0], table_full[1]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [cbq_pkg::BytesW-1:0] threshold_q;
  logic [cbq_pkg::TimerW-1:0] reload_q;
  logic                       item_valid;
  logic                       item_pop;
  cbq_pkg::cbq_item_t         item;
  cbq_pkg::cbq_result_t       res;

  // Configuration registers; hold their value unless written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= cbq_pkg::THRESHOLD_RST;
      reload_q    <= cbq_pkg::RELOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbq_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        cbq_pkg::CFG_RELOAD:    reload_q    <= cfg_data_i[cbq_pkg::TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

  cbq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_mode_i    (s_axis_tdata_i[1:0]),
    .in_addr_i    (s_axis_tdata_i[33:2]),
    .in_bytes_i   (s_axis_tdata_i[65:34]),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  cbq_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .threshold_i  (threshold_q),
    .reload_i     (reload_q),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  // Pad bits 7:2 of the result byte are zero
  assign m_axis_tdata_o = {6'b0, res.table_full, res.over_limit};

endmodule

### hw/rtl/cbq_front.sv
// Front end of the client byte quota table: accepts stream transfers, decodes the mode
// and holds up to two classified items for the lookup engine.
// Depends on cbq_pkg.
module cbq_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cbq_pkg::ModeW-1:0]    in_mode_i,
  input  logic [cbq_pkg::AddrW-1:0]    in_addr_i,
  input  logic [cbq_pkg::BytesW-1:0]   in_bytes_i,
  output logic                         item_valid_o,
  input  logic                         item_pop_i,
  output cbq_pkg::cbq_item_t           item_o
);

  cbq_pkg::cbq_item_t fifo_q [2];
  cbq_pkg::cbq_item_t item_in;
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               push, pop;

  // Classify the request
  always_comb begin
    item_in.addr  = in_addr_i;
    item_in.bytes = in_bytes_i;
    unique case (in_mode_i)
      cbq_pkg::MODE_ADD:     item_in.kind = cbq_pkg::KIND_ADD;
      cbq_pkg::MODE_CHECK:   item_in.kind = cbq_pkg::KIND_CHECK;
      cbq_pkg::MODE_RELEASE: item_in.kind = cbq_pkg::KIND_RELEASE;
      default:               item_in.kind = cbq_pkg::KIND_NONE;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### hw/rtl/cbq_engine.sv
// Back end of the client byte quota table: scans the client table one slot a cycle,
// updates the matching or a free slot and registers the result.
// Depends on cbq_pkg.
module cbq_engine #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_pop_o,
  input  cbq_pkg::cbq_item_t          item_i,
  input  logic [cbq_pkg::BytesW-1:0]  threshold_i,
  input  logic [cbq_pkg::TimerW-1:0]  reload_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output cbq_pkg::cbq_result_t        res_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW:0] CntEnd = (IdxW+1)'(TABLE_ENTRIES);

  // Table storage
  logic [cbq_pkg::AddrW-1:0]  addr_mem  [TABLE_ENTRIES];
  logic [cbq_pkg::BytesW-1:0] bytes_mem [TABLE_ENTRIES];
  logic [cbq_pkg::TimerW-1:0] timer_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_q;

  cbq_pkg::cbq_state_e        state_q, state_d;
  cbq_pkg::cbq_item_t         cur_q, cur_d;
  logic [IdxW:0]              cnt_q, cnt_d;
  logic                       rd_live_q, rd_live_d;
  logic [IdxW-1:0]            rd_idx_q;
  logic [cbq_pkg::AddrW-1:0]  rd_addr_q;
  logic [cbq_pkg::BytesW-1:0] rd_bytes_q;
  logic [cbq_pkg::TimerW-1:0] rd_timer_q;
  logic                       hit_q, hit_d;
  logic [IdxW-1:0]            slot_q, slot_d;
  logic [cbq_pkg::BytesW-1:0] hb_q, hb_d;
  logic [cbq_pkg::TimerW-1:0] ht_q, ht_d;
  logic                       free_q, free_d;
  logic [IdxW-1:0]            free_idx_q, free_idx_d;
  logic [cbq_pkg::BytesW-1:0] arith_q, arith_d;
  logic                       res_valid_q, res_valid_d;
  cbq_pkg::cbq_result_t       res_q, res_d;

  logic                       issue;
  logic [cbq_pkg::BytesW:0]   sum;
  logic [IdxW-1:0]            wr_idx;
  logic                       addr_we, bytes_we, timer_we, valid_set, valid_clr;
  logic [cbq_pkg::BytesW-1:0] bytes_wd;
  logic [cbq_pkg::TimerW-1:0] timer_wd;

  assign issue       = (state_q == cbq_pkg::ST_SCAN) && (cnt_q != CntEnd);
  assign sum         = {1'b0, hb_q} + {1'b0, cur_q.bytes};
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    rd_live_d   = issue;
    hit_d       = hit_q;
    slot_d      = slot_q;
    hb_d        = hb_q;
    ht_d        = ht_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    arith_d     = arith_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    item_pop_o  = 1'b0;
    wr_idx      = slot_q;
    addr_we     = 1'b0;
    bytes_we    = 1'b0;
    bytes_wd    = arith_q;
    timer_we    = 1'b0;
    timer_wd    = reload_i;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;

    unique case (state_q)
      cbq_pkg::ST_IDLE: begin
        // Take the next item once the result slot is free or draining
        if (item_valid_i && (!res_valid_q || res_ready_i)) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          cnt_d      = '0;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          state_d    = cbq_pkg::ST_SCAN;
        end
      end
      cbq_pkg::ST_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rd_live_q && valid_q[rd_idx_q] && (rd_addr_q == cur_q.addr)) begin
          hit_d   = 1'b1;
          slot_d  = rd_idx_q;
          hb_d    = rd_bytes_q;
          ht_d    = rd_timer_q;
          state_d = cbq_pkg::ST_CALC;
        end else begin
          if (rd_live_q && !valid_q[rd_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (!rd_live_q && (cnt_q == CntEnd)) begin
            state_d = cbq_pkg::ST_CALC;
          end
        end
      end
      cbq_pkg::ST_CALC: begin
        // Saturating add for add mode, floor-at-zero subtract for release
        if (cur_q.kind == cbq_pkg::KIND_ADD) begin
          arith_d = sum[cbq_pkg::BytesW] ? '1 : sum[cbq_pkg::BytesW-1:0];
        end else begin
          arith_d = (cur_q.bytes >= hb_q) ? '0 : hb_q - cur_q.bytes;
        end
        state_d = cbq_pkg::ST_WRITE;
      end
      cbq_pkg::ST_WRITE: begin
        res_d       = '0;
        res_valid_d = 1'b1;
        state_d     = cbq_pkg::ST_IDLE;
        unique case (cur_q.kind)
          cbq_pkg::KIND_ADD: begin
            if (hit_q) begin
              bytes_we = 1'b1;
              timer_we = (arith_q > threshold_i);
            end else if (free_q) begin
              wr_idx    = free_idx_q;
              valid_set = 1'b1;
              addr_we   = 1'b1;
              bytes_we  = 1'b1;
              bytes_wd  = cur_q.bytes;
              timer_we  = 1'b1;
              timer_wd  = '0;
            end else begin
              res_d.table_full = 1'b1;
            end
          end
          cbq_pkg::KIND_CHECK: begin
            if (hit_q) begin
              if (ht_q != '0) begin
                timer_we         = 1'b1;
                res_d.over_limit = 1'b1;
              end else begin
                res_d.over_limit = (hb_q > threshold_i);
              end
            end
          end
          cbq_pkg::KIND_RELEASE: begin
            if (hit_q) begin
              bytes_we  = 1'b1;
              valid_clr = (arith_q == '0);
            end
          end
          default: begin
          end
        endcase
      end
      default: state_d = cbq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbq_pkg::ST_IDLE;
      rd_live_q   <= 1'b0;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      rd_live_q   <= rd_live_d;
      res_valid_q <= res_valid_d;
      if (valid_set) begin
        valid_q[wr_idx] <= 1'b1;
      end else if (valid_clr) begin
        valid_q[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    cnt_q      <= cnt_d;
    hit_q      <= hit_d;
    slot_q     <= slot_d;
    hb_q       <= hb_d;
    ht_q       <= ht_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    arith_q    <= arith_d;
    res_q      <= res_d;
  end

  // Table memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= cnt_q[IdxW-1:0];
    rd_addr_q  <= addr_mem[cnt_q[IdxW-1:0]];
    rd_bytes_q <= bytes_mem[cnt_q[IdxW-1:0]];
    rd_timer_q <= timer_mem[cnt_q[IdxW-1:0]];
    if (addr_we) begin
      addr_mem[wr_idx] <= cur_q.addr;
    end
    if (bytes_we) begin
      bytes_mem[wr_idx] <= bytes_wd;
    end
    if (timer_we) begin
      timer_mem[wr_idx] <= timer_wd;
    end
  end

endmodule

### hw/rtl/cbq_checker.sv
// Port checker for the client byte quota table, bound to the top level.
// Depends only on the top level's ports.
module cbq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  logic [7:0] pending_q;

  // Count requests whose result has not been transferred yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {7'b0, s_axis_tvalid_i && s_axis_tready_o}
                             - {7'b0, m_axis_tvalid_o && m_axis_tready_i};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("over_limit and table_full both set");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != 8'd0)
    else $error("result without a pending request");

endmodule

bind client_byte_quota_table cbq_checker u_cbq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
